// ----- rtl/stepper_phase_sequencer_top_assert.svh -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_top_assert
// Assertion macros used by the sequencer core.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SPSQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/spsq_pkg.sv -----
// ----------------------------------------------------------------------------
// spsq_pkg
// Types, constants and the coil pattern table of the stepper phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package spsq_pkg;

   localparam int unsigned INTERVAL_W  = 19;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned INDEX_W     = 3;
   localparam int unsigned KEY_W       = 8;
   localparam int unsigned COIL_W      = 4;
   localparam int unsigned CSR_INDEX_W = 2;

   typedef logic [INTERVAL_W-1:0]  interval_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [INDEX_W-1:0]     index_type;
   typedef logic [KEY_W-1:0]       key_type;
   typedef logic [COIL_W-1:0]      coil_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   typedef enum logic [1:0] {
      MODE_OFF       = 2'd0,
      MODE_TWO_PHASE = 2'd1,
      MODE_HALF_STEP = 2'd2,
      MODE_WAVE      = 2'd3
   } drive_mode_type;

   localparam csr_index_type CSR_MIN_INTERVAL = 2'd0;
   localparam csr_index_type CSR_MAX_INTERVAL = 2'd1;
   localparam csr_index_type CSR_COUNTDOWN    = 2'd2;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_KEY  = 1'b1;

   localparam key_type KEY_TWO_PHASE = 8'h31;
   localparam key_type KEY_HALF_STEP = 8'h32;
   localparam key_type KEY_WAVE      = 8'h34;
   localparam key_type KEY_SPACE     = 8'h20;
   localparam key_type KEY_ZERO      = 8'h30;
   localparam key_type KEY_FASTER    = 8'h2B;
   localparam key_type KEY_SLOWER    = 8'h2D;
   localparam key_type KEY_REVERSE   = 8'h72;
   localparam key_type KEY_COUNTDOWN = 8'h63;
   localparam key_type KEY_ESCAPE    = 8'h1B;

   localparam interval_type MIN_INTERVAL_RST = 19'd300;
   localparam interval_type MAX_INTERVAL_RST = 19'd500000;
   localparam count_type    COUNTDOWN_RST    = 13'd4096;

   // floor(x/3) for 21-bit x, floor(x/5) for 19-bit x
   localparam logic [21:0] DIV3_MUL = 22'd1398102;
   localparam int unsigned DIV3_SHIFT = 22;
   localparam logic [18:0] DIV5_MUL = 19'd419431;
   localparam int unsigned DIV5_SHIFT = 21;

   typedef struct packed {
      logic    req_type;
      key_type key;
   } req_item_type;

   typedef struct packed {
      interval_type min_interval;
      interval_type max_interval;
      count_type    countdown_length;
   } cfg_type;

   localparam coil_type PATTERN [4][8] = '{
      '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
      '{4'h3, 4'h3, 4'h6, 4'h6, 4'hC, 4'hC, 4'h9, 4'h9},
      '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9},
      '{4'h1, 4'h1, 4'h2, 4'h2, 4'h4, 4'h4, 4'h8, 4'h8}
   };

   function automatic coil_type coil_pattern(drive_mode_type mode, index_type idx);
      return PATTERN[mode][idx];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/spsq_req_if.sv -----
// ----------------------------------------------------------------------------
// spsq_req_if
// Request channel: tick or key transactions into the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface spsq_req_if;
   logic              valid;
   logic              ready;
   logic              req_type;
   spsq_pkg::key_type key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

`default_nettype wire

// ----- rtl/spsq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spsq_rsp_if
// Response channel: one coil status transaction per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface spsq_rsp_if;
   logic                   valid;
   logic                   ready;
   spsq_pkg::coil_type     coils;
   logic                   drive_enable;
   logic                   stepped;
   spsq_pkg::interval_type interval_now;

   modport source (output valid, output coils, output drive_enable, output stepped,
                   output interval_now, input ready);
   modport sink   (input valid, input coils, input drive_enable, input stepped,
                   input interval_now, output ready);
endinterface

`default_nettype wire

// ----- rtl/spsq_csr.sv -----
// ----------------------------------------------------------------------------
// spsq_csr
// Configuration registers: interval limits and countdown length.
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire spsq_pkg::csr_index_type   csr_index,
   input  wire spsq_pkg::interval_type    csr_wdata,
   output spsq_pkg::cfg_type              cfg
);

   spsq_pkg::cfg_type cfg_ff;
   spsq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            spsq_pkg::CSR_MIN_INTERVAL: cfg_in.min_interval = csr_wdata;
            spsq_pkg::CSR_MAX_INTERVAL: cfg_in.max_interval = csr_wdata;
            spsq_pkg::CSR_COUNTDOWN:
               cfg_in.countdown_length = csr_wdata[spsq_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval     <= spsq_pkg::MIN_INTERVAL_RST;
         cfg_ff.max_interval     <= spsq_pkg::MAX_INTERVAL_RST;
         cfg_ff.countdown_length <= spsq_pkg::COUNTDOWN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/spsq_in_stage.sv -----
// ----------------------------------------------------------------------------
// spsq_in_stage
// Input register for request transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   spsq_req_if.sink                    req_chan,
   output logic                        stg_valid,
   output spsq_pkg::req_item_type      stg_item,
   input  wire logic                   stg_ready
);

   logic                   valid_ff;
   logic                   valid_in;
   spsq_pkg::req_item_type item_ff;
   spsq_pkg::req_item_type item_in;
   logic                   load;

   assign req_chan.ready = !valid_ff || stg_ready;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_chan.ready) begin
         valid_in = req_chan.valid;
      end
      if (load) begin
         item_in.req_type = req_chan.req_type;
         item_in.key      = req_chan.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stg_valid = valid_ff;
   assign stg_item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/spsq_core.sv -----
// ----------------------------------------------------------------------------
// spsq_core
// Sequencer state, tick/key update and response register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_phase_sequencer_top_assert.svh"

module spsq_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spsq_pkg::cfg_type      cfg,
   input  wire logic                   stg_valid,
   input  wire spsq_pkg::req_item_type stg_item,
   output logic                        stg_ready,
   spsq_rsp_if.source                  rsp_chan
);

   spsq_pkg::interval_type   interval_ff, interval_in;
   spsq_pkg::interval_type   wait_ff, wait_in;
   spsq_pkg::index_type      index_ff, index_in;
   spsq_pkg::drive_mode_type mode_ff, mode_in;
   logic                     forward_ff, forward_in;
   spsq_pkg::count_type      steps_ff, steps_in;
   spsq_pkg::coil_type       coil_ff, coil_in;
   logic                     released_ff, released_in;

   logic                     res_valid_ff, res_valid_in;
   spsq_pkg::coil_type       res_coils_ff, res_coils_in;
   logic                     res_drive_ff, res_drive_in;
   logic                     res_stepped_ff, res_stepped_in;
   spsq_pkg::interval_type   res_interval_ff, res_interval_in;

   logic                     load_result;
   logic                     update;
   logic [spsq_pkg::INTERVAL_W:0] wait_next;
   logic                     step_now;
   spsq_pkg::count_type      steps_dec;

   logic [21:0]              times5;
   logic [20:0]              half5;
   logic [42:0]              prod3;
   logic [37:0]              prod5;
   spsq_pkg::interval_type   faster;
   logic [spsq_pkg::INTERVAL_W:0] slower;

   logic                     rel_load;
   logic                     rel_rsp;
   logic                     wait_ok;
   logic                     step_load;
   logic                     step_rsp;

   assign stg_ready   = !res_valid_ff || rsp_chan.ready;
   assign load_result = stg_ready;
   assign update      = stg_valid && stg_ready && !released_ff;

   assign wait_next = {1'b0, wait_ff} + 20'd1;
   assign step_now  = wait_next >= {1'b0, interval_ff};
   assign steps_dec = steps_ff - 13'd1;

   // 5/6: (5i >> 1) / 3, 6/5: i + i / 5
   assign times5 = {3'b000, interval_ff} + {1'b0, interval_ff, 2'b00};
   assign half5  = times5[21:1];
   assign prod3  = 43'(half5) * 43'(spsq_pkg::DIV3_MUL);
   assign prod5  = 38'(interval_ff) * 38'(spsq_pkg::DIV5_MUL);
   assign faster = prod3[spsq_pkg::DIV3_SHIFT +: spsq_pkg::INTERVAL_W];
   assign slower = {1'b0, interval_ff} + 20'(prod5[37:spsq_pkg::DIV5_SHIFT]);

   always_comb begin
      interval_in    = interval_ff;
      wait_in        = wait_ff;
      index_in       = index_ff;
      mode_in        = mode_ff;
      forward_in     = forward_ff;
      steps_in       = steps_ff;
      coil_in        = coil_ff;
      released_in    = released_ff;
      res_stepped_in = 1'b0;
      if (update) begin
         if (stg_item.req_type == spsq_pkg::REQ_TICK) begin
            if (step_now) begin
               coil_in        = spsq_pkg::coil_pattern(mode_ff, index_ff);
               index_in       = forward_ff ? index_ff + 3'd1 : index_ff - 3'd1;
               wait_in        = '0;
               res_stepped_in = 1'b1;
               if (steps_ff != '0) begin
                  steps_in = steps_dec;
                  if (steps_dec == '0) begin
                     mode_in = spsq_pkg::MODE_OFF;
                  end
               end
            end else begin
               wait_in = wait_next[spsq_pkg::INTERVAL_W-1:0];
            end
         end else begin
            wait_in = '0;
            case (stg_item.key)
               spsq_pkg::KEY_TWO_PHASE: mode_in = spsq_pkg::MODE_TWO_PHASE;
               spsq_pkg::KEY_HALF_STEP: mode_in = spsq_pkg::MODE_HALF_STEP;
               spsq_pkg::KEY_WAVE:      mode_in = spsq_pkg::MODE_WAVE;
               spsq_pkg::KEY_SPACE,
               spsq_pkg::KEY_ZERO:      mode_in = spsq_pkg::MODE_OFF;
               spsq_pkg::KEY_FASTER: begin
                  interval_in = (faster < cfg.min_interval) ? cfg.min_interval : faster;
               end
               spsq_pkg::KEY_SLOWER: begin
                  interval_in = (slower > {1'b0, cfg.max_interval}) ?
                                cfg.max_interval : slower[spsq_pkg::INTERVAL_W-1:0];
               end
               spsq_pkg::KEY_REVERSE:   forward_in  = !forward_ff;
               spsq_pkg::KEY_COUNTDOWN: steps_in    = cfg.countdown_length;
               spsq_pkg::KEY_ESCAPE:    released_in = 1'b1;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      res_valid_in    = res_valid_ff;
      res_coils_in    = res_coils_ff;
      res_drive_in    = res_drive_ff;
      res_interval_in = res_interval_ff;
      if (load_result) begin
         res_valid_in    = stg_valid;
         res_coils_in    = released_in ? '0 : coil_in;
         res_drive_in    = !released_in;
         res_interval_in = interval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= spsq_pkg::MAX_INTERVAL_RST;
         wait_ff      <= '0;
         index_ff     <= '0;
         mode_ff      <= spsq_pkg::MODE_OFF;
         forward_ff   <= 1'b1;
         steps_ff     <= '0;
         coil_ff      <= '0;
         released_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         wait_ff      <= wait_in;
         index_ff     <= index_in;
         mode_ff      <= mode_in;
         forward_ff   <= forward_in;
         steps_ff     <= steps_in;
         coil_ff      <= coil_in;
         released_ff  <= released_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_coils_ff    <= res_coils_in;
      res_drive_ff    <= res_drive_in;
      res_interval_ff <= res_interval_in;
      if (load_result) begin
         res_stepped_ff <= res_stepped_in;
      end
   end

   assign rsp_chan.valid        = res_valid_ff;
   assign rsp_chan.coils        = res_coils_ff;
   assign rsp_chan.drive_enable = res_drive_ff;
   assign rsp_chan.stepped      = res_stepped_ff;
   assign rsp_chan.interval_now = res_interval_ff;

   assign rel_load  = load_result && stg_valid && released_in;
   assign rel_rsp   = rsp_chan.valid && !rsp_chan.drive_enable && rsp_chan.coils == '0 &&
                      !rsp_chan.stepped;
   assign wait_ok   = wait_ff < interval_ff;
   assign step_load = update && res_stepped_in;
   assign step_rsp  = wait_ff == '0 && rsp_chan.stepped;

   `SPSQ_ASSERT_NEXT(a_release_sticky, clock, reset, released_ff, released_ff, "release dropped")
   `SPSQ_ASSERT_NEXT(a_release_quiet, clock, reset, rel_load, rel_rsp, "release not quiet")
   `SPSQ_ASSERT_SAME(a_wait_bound, clock, reset, wait_ff != '0, wait_ok, "wait passed interval")
   `SPSQ_ASSERT_NEXT(a_step_wait, clock, reset, step_load, step_rsp, "step kept the wait")

endmodule

`default_nettype wire

// ----- rtl/stepper_phase_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_top
// Unipolar stepper phase sequencer with tick/key requests and coil responses.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries transactions: req_type 0 is a one-microsecond tick,
//   req_type 1 a key code in key. Every request yields exactly one
//   rsp_chan transaction with the latched coil pattern, drive enable, a
//   stepped flag and the current interval.
//   A request passes the input register, then the state update and the
//   response register; a stall on rsp_chan holds it in the input register.
//   Throughput is one transaction per cycle while rsp_chan does not stall;
//   the 5/6 and 6/5 interval scaling uses constant reciprocal multipliers.
//   csr_we writes min_interval (index 0), max_interval (1) or
//   countdown_length (2) from csr_wdata; write only while idle.
//   Reset clears both stages, restores the register defaults and sets the
//   interval to 500000, mode off, direction forward.
//   When rsp_chan stalls, the response holds, one more request is taken
//   into the input register, then req_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   spsq_req_if.sink                     req_chan,
   spsq_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_we,
   input  wire spsq_pkg::csr_index_type csr_index,
   input  wire spsq_pkg::interval_type  csr_wdata
);

   spsq_pkg::cfg_type      cfg;
   logic                   stg_valid;
   logic                   stg_ready;
   spsq_pkg::req_item_type stg_item;

   spsq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spsq_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .stg_valid (stg_valid),
      .stg_item  (stg_item),
      .stg_ready (stg_ready)
   );

   spsq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .stg_valid (stg_valid),
      .stg_item  (stg_item),
      .stg_ready (stg_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- test/stepper_phase_sequencer_top_tb.sv -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_top_tb
// Drives tick and key transactions into the stepper phase sequencer and
// checks every coil status response against a local model of the step
// timing, pattern table, rate scaling, countdown and release logic. A
// directed table comes first, then randomized key-plus-tick-run segments
// under several register settings, then the escape key and a released tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_phase_sequencer_top_tb;

   localparam spsq_pkg::key_type       KEY_NUL      = 8'h00;
   localparam spsq_pkg::key_type       KEY_ALL_ONES = 8'hFF;
   localparam spsq_pkg::key_type       KEY_OTHER    = 8'h78;
   localparam spsq_pkg::csr_index_type CSR_UNUSED   = 2'd3;
   localparam int            HOLD_OFF_CYCLES = 90;
   localparam int            PHASE_ITEMS [5] = '{120, 120, 110, 40, 50};
   localparam int            RELEASED_ITEMS  = 20;
   localparam int            MAX_PRINTED     = 40;

   localparam spsq_pkg::coil_type COIL_TABLE [4][8] = '{
      '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
      '{4'h3, 4'h3, 4'h6, 4'h6, 4'hC, 4'hC, 4'h9, 4'h9},
      '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9},
      '{4'h1, 4'h1, 4'h2, 4'h2, 4'h4, 4'h4, 4'h8, 4'h8}
   };

   localparam spsq_pkg::key_type RUN_KEYS [9] = '{
      spsq_pkg::KEY_TWO_PHASE, spsq_pkg::KEY_HALF_STEP, spsq_pkg::KEY_WAVE,
      spsq_pkg::KEY_SPACE, spsq_pkg::KEY_ZERO, spsq_pkg::KEY_FASTER,
      spsq_pkg::KEY_SLOWER, spsq_pkg::KEY_REVERSE, spsq_pkg::KEY_COUNTDOWN
   };

   typedef struct packed {
      spsq_pkg::coil_type     coils;
      logic                   drive_enable;
      logic                   stepped;
      spsq_pkg::interval_type interval_now;
   } coil_status_type;

   typedef struct {
      spsq_pkg::interval_type   interval;
      spsq_pkg::interval_type   wait_count;
      spsq_pkg::index_type      step_index;
      spsq_pkg::drive_mode_type mode;
      logic                     forward;
      spsq_pkg::count_type      steps_left;
      spsq_pkg::coil_type       coil_latch;
      logic                     released;
   } seq_state_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum {RX_STREAM, RX_RANDOM, RX_PERIODIC} rx_style_type;

   typedef struct {
      row_kind_type            kind;
      logic                    is_key;
      spsq_pkg::key_type       key;
      spsq_pkg::csr_index_type idx;
      spsq_pkg::interval_type  data;
      logic                    typed;
      coil_status_type         want;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   spsq_pkg::csr_index_type csr_index;
   spsq_pkg::interval_type  csr_wdata;

   spsq_req_if req_chan ();
   spsq_rsp_if rsp_chan ();

   stepper_phase_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   seq_state_type     seq;
   spsq_pkg::cfg_type cfg;
   coil_status_type   pending_status [$];
   stim_row_type      stim_rows [$];

   int   burst_left  = 0;
   int   errors      = 0;
   int   items_sent  = 0;
   int   keys_sent   = 0;
   int   steps_seen  = 0;
   int   checked     = 0;
   int   hold_offs   = 0;
   logic hold_off_pending = 1'b0;

   always #6 clock = ~clock;

   initial begin
      #3_000_000;
      $display("Timeout with %0d responses outstanding", pending_status.size());
      $display("stepper_phase_sequencer_top_tb NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Model of the sequencer state
   // ------------------------------------------------------------------------
   function automatic void reset_model();
      cfg.min_interval     = 19'd300;
      cfg.max_interval     = 19'd500000;
      cfg.countdown_length = 13'd4096;
      seq.interval   = 19'd500000;
      seq.wait_count = '0;
      seq.step_index = '0;
      seq.mode       = spsq_pkg::MODE_OFF;
      seq.forward    = 1'b1;
      seq.steps_left = '0;
      seq.coil_latch = '0;
      seq.released   = 1'b0;
   endfunction

   function automatic coil_status_type advance_sequencer(logic is_key, spsq_pkg::key_type k);
      coil_status_type r;
      int unsigned     next_wait;
      int unsigned     scaled;
      r.stepped = 1'b0;
      if (!seq.released) begin
         if (is_key == spsq_pkg::REQ_TICK) begin
            next_wait = seq.wait_count + 1;
            if (next_wait >= seq.interval) begin
               seq.coil_latch = COIL_TABLE[seq.mode][seq.step_index];
               seq.step_index = seq.forward ? seq.step_index + 3'd1 : seq.step_index - 3'd1;
               if (seq.steps_left != 0) begin
                  seq.steps_left = seq.steps_left - 1'b1;
                  if (seq.steps_left == 0)
                     seq.mode = spsq_pkg::MODE_OFF;
               end
               seq.wait_count = '0;
               r.stepped = 1'b1;
            end else begin
               seq.wait_count = next_wait[spsq_pkg::INTERVAL_W-1:0];
            end
         end else begin
            seq.wait_count = '0;
            case (k)
               spsq_pkg::KEY_TWO_PHASE: seq.mode = spsq_pkg::MODE_TWO_PHASE;
               spsq_pkg::KEY_HALF_STEP: seq.mode = spsq_pkg::MODE_HALF_STEP;
               spsq_pkg::KEY_WAVE:      seq.mode = spsq_pkg::MODE_WAVE;
               spsq_pkg::KEY_SPACE,
               spsq_pkg::KEY_ZERO:      seq.mode = spsq_pkg::MODE_OFF;
               spsq_pkg::KEY_FASTER: begin
                  scaled = seq.interval;
                  scaled = scaled * 5 / 6;
                  if (scaled < cfg.min_interval)
                     scaled = cfg.min_interval;
                  seq.interval = scaled[spsq_pkg::INTERVAL_W-1:0];
               end
               spsq_pkg::KEY_SLOWER: begin
                  scaled = seq.interval;
                  scaled = scaled * 6 / 5;
                  if (scaled > cfg.max_interval)
                     scaled = cfg.max_interval;
                  seq.interval = scaled[spsq_pkg::INTERVAL_W-1:0];
               end
               spsq_pkg::KEY_REVERSE:   seq.forward = ~seq.forward;
               spsq_pkg::KEY_COUNTDOWN: seq.steps_left = cfg.countdown_length;
               spsq_pkg::KEY_ESCAPE:    seq.released = 1'b1;
               default: ;
            endcase
         end
      end
      r.coils        = seq.released ? 4'h0 : seq.coil_latch;
      r.drive_enable = ~seq.released;
      r.interval_now = seq.interval;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic void add_item(logic is_key, spsq_pkg::key_type k);
      stim_row_type row;
      row.kind   = ROW_ITEM;
      row.is_key = is_key;
      row.key    = k;
      row.idx    = spsq_pkg::CSR_MIN_INTERVAL;
      row.data   = '0;
      row.typed  = 1'b0;
      row.want   = '0;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_item_want(logic is_key, spsq_pkg::key_type k,
                                         spsq_pkg::coil_type coils,
                                         spsq_pkg::interval_type iv);
      add_item(is_key, k);
      stim_rows[$].typed = 1'b1;
      stim_rows[$].want  = '{coils: coils, drive_enable: 1'b1, stepped: 1'b0,
                            interval_now: iv};
   endfunction

   function automatic void add_csr(spsq_pkg::csr_index_type idx,
                                   spsq_pkg::interval_type data);
      add_item(spsq_pkg::REQ_TICK, KEY_NUL);
      stim_rows[$].kind = ROW_CSR;
      stim_rows[$].idx  = idx;
      stim_rows[$].data = data;
   endfunction

   task automatic offer_transaction(input logic is_key, input spsq_pkg::key_type k,
                                    input logic typed, input coil_status_type want);
      int              gap;
      bit              fire;
      coil_status_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= is_key;
      req_chan.key      <= k;
      fire = 1'b0;
      while (!fire) begin
         @(negedge clock);
         fire = (req_chan.ready === 1'b1);
         @(posedge clock);
      end
      predicted = advance_sequencer(is_key, k);
      pending_status.push_back(typed ? want : predicted);
      items_sent++;
      if (is_key == spsq_pkg::REQ_KEY)
         keys_sent++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input spsq_pkg::csr_index_type idx,
                                 input spsq_pkg::interval_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         spsq_pkg::CSR_MIN_INTERVAL: cfg.min_interval     = data;
         spsq_pkg::CSR_MAX_INTERVAL: cfg.max_interval     = data;
         spsq_pkg::CSR_COUNTDOWN:    cfg.countdown_length = data[spsq_pkg::COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // one key (usually) followed by a random run of ticks, capped at 2*interval+3 or at 40
   task automatic run_segment();
      int                pick;
      int                cap;
      int                run_len;
      spsq_pkg::key_type k;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         offer_transaction(spsq_pkg::REQ_KEY, RUN_KEYS[$urandom_range(0, 8)], 1'b0, '0);
      end else if (pick == 7) begin
         k = spsq_pkg::key_type'($urandom_range(0, 255));
         if (k == spsq_pkg::KEY_ESCAPE)
            k = KEY_OTHER;
         offer_transaction(spsq_pkg::REQ_KEY, k, 1'b0, '0);
      end
      cap = (seq.interval > 20) ? 40 : 2 * seq.interval + 3;
      run_len = $urandom_range(0, cap);
      repeat (run_len)
         offer_transaction(spsq_pkg::REQ_TICK, spsq_pkg::key_type'($urandom_range(0, 255)),
                           1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   initial begin : response_receiver
      rx_style_type style;
      int           style_left;
      int           hold_left;
      int           cycle;
      style      = RX_STREAM;
      style_left = 0;
      hold_left  = 0;
      cycle      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
            hold_offs++;
         end
         if (reset || hold_left > 0) begin
            if (hold_left > 0)
               hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = rx_style_type'($urandom_range(0, 2));
               style_left = $urandom_range(20, 160);
            end
            style_left--;
            case (style)
               RX_STREAM:   rsp_chan.ready <= 1'b1;
               RX_RANDOM:   rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_chan.ready <= ((cycle % 7) < 3);
               default:     rsp_chan.ready <= 1'b1;
            endcase
         end
      end
   end

   initial begin : response_monitor
      coil_status_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            checked++;
            if (rsp_chan.stepped === 1'b1)
               steps_seen++;
            if (pending_status.size() == 0) begin
               report_mismatch("response transaction with nothing pending");
            end else begin
               want = pending_status.pop_front();
               if (rsp_chan.coils !== want.coils)
                  report_mismatch($sformatf("rsp %0d coils 0x%0h, expected 0x%0h",
                                            checked, rsp_chan.coils, want.coils));
               if (rsp_chan.drive_enable !== want.drive_enable)
                  report_mismatch($sformatf("rsp %0d drive_enable %b, expected %b",
                                            checked, rsp_chan.drive_enable,
                                            want.drive_enable));
               if (rsp_chan.stepped !== want.stepped)
                  report_mismatch($sformatf("rsp %0d stepped %b, expected %b",
                                            checked, rsp_chan.stepped, want.stepped));
               if (rsp_chan.interval_now !== want.interval_now)
                  report_mismatch($sformatf("rsp %0d interval_now %0d, expected %0d",
                                            checked, rsp_chan.interval_now,
                                            want.interval_now));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      bit                     csr_open;
      spsq_pkg::interval_type lo;
      spsq_pkg::interval_type hi;
      spsq_pkg::count_type    cd;
      int                     target;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = spsq_pkg::CSR_MIN_INTERVAL;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.req_type = spsq_pkg::REQ_TICK;
      req_chan.key      = KEY_NUL;
      reset_model();

      // directed table; typed rows carry their own expected response instead of the model's
      add_item_want(spsq_pkg::REQ_TICK, KEY_ALL_ONES,         4'h0, 19'd500000);
      add_item_want(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_SLOWER, 4'h0, 19'd500000);
      add_item_want(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_FASTER, 4'h0, 19'd416666);
      add_item_want(spsq_pkg::REQ_KEY,  KEY_NUL,              4'h0, 19'd416666);
      add_csr(spsq_pkg::CSR_MIN_INTERVAL, 19'd1);
      add_csr(spsq_pkg::CSR_MAX_INTERVAL, 19'd3);
      add_csr(spsq_pkg::CSR_COUNTDOWN,    19'd1);
      add_item_want(spsq_pkg::REQ_KEY, spsq_pkg::KEY_SLOWER,    4'h0, 19'd3);
      add_item_want(spsq_pkg::REQ_KEY, spsq_pkg::KEY_HALF_STEP, 4'h0, 19'd3);
      add_item(spsq_pkg::REQ_TICK, KEY_NUL);
      add_item(spsq_pkg::REQ_TICK, KEY_ALL_ONES);
      add_item(spsq_pkg::REQ_TICK, KEY_NUL);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_FASTER);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_FASTER);
      add_item_want(spsq_pkg::REQ_KEY, spsq_pkg::KEY_FASTER, 4'h1, 19'd1);
      add_item(spsq_pkg::REQ_TICK, KEY_ALL_ONES);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_REVERSE);
      add_item(spsq_pkg::REQ_TICK, KEY_NUL);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_COUNTDOWN);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_TWO_PHASE);
      add_item(spsq_pkg::REQ_TICK, KEY_NUL);
      add_item(spsq_pkg::REQ_TICK, KEY_NUL);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_WAVE);
      add_item(spsq_pkg::REQ_TICK, KEY_ALL_ONES);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_SPACE);
      add_item(spsq_pkg::REQ_KEY,  spsq_pkg::KEY_ZERO);
      add_item(spsq_pkg::REQ_KEY,  KEY_OTHER);
      add_item(spsq_pkg::REQ_TICK, KEY_NUL);
      add_csr(spsq_pkg::CSR_MIN_INTERVAL, 19'd524287);
      add_csr(spsq_pkg::CSR_MAX_INTERVAL, 19'd1);
      add_csr(spsq_pkg::CSR_COUNTDOWN,    19'd8191);
      add_item_want(spsq_pkg::REQ_KEY, spsq_pkg::KEY_FASTER, 4'h0, 19'd524287);
      add_item_want(spsq_pkg::REQ_KEY, spsq_pkg::KEY_SLOWER, 4'h0, 19'd1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      csr_open = 1'b0;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            if (!csr_open)
               wait_idle();
            write_register(stim_rows[i].idx, stim_rows[i].data);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_we   <= 1'b0;
               csr_open = 1'b0;
            end
            offer_transaction(stim_rows[i].is_key, stim_rows[i].key,
                              stim_rows[i].typed, stim_rows[i].want);
         end
      end

      for (int ph = 0; ph < 5; ph++) begin
         wait_idle();
         case (ph)
            0: begin lo = 19'd1; hi = 19'd8;  cd = 13'd5;    end
            1: begin lo = 19'd2; hi = 19'd20; cd = 13'd8191; end
            2: begin
               lo = spsq_pkg::interval_type'($urandom_range(1, 6));
               hi = spsq_pkg::interval_type'($urandom_range(6, 30));
               cd = spsq_pkg::count_type'($urandom_range(1, 40));
            end
            3: begin lo = 19'd524287; hi = 19'd1; cd = 13'd1; end
            default: begin
               lo = 19'd1;
               hi = 19'd524287;
               cd = spsq_pkg::count_type'($urandom_range(1, 8191));
            end
         endcase
         write_register(spsq_pkg::CSR_MIN_INTERVAL, lo);
         write_register(spsq_pkg::CSR_MAX_INTERVAL, hi);
         write_register(spsq_pkg::CSR_COUNTDOWN, spsq_pkg::interval_type'(cd));
         if (ph == 2)
            write_register(CSR_UNUSED, spsq_pkg::interval_type'($urandom));
         csr_we <= 1'b0;
         if (ph == 0 || ph == 2)
            hold_off_pending = 1'b1;
         target = items_sent + PHASE_ITEMS[ph];
         while (items_sent < target)
            run_segment();
      end

      // escape releases the coils for the rest of the run
      offer_transaction(spsq_pkg::REQ_KEY, spsq_pkg::KEY_ESCAPE, 1'b0, '0);
      repeat (RELEASED_ITEMS)
         offer_transaction(logic'($urandom_range(0, 1)),
                           spsq_pkg::key_type'($urandom_range(0, 255)), 1'b0, '0);

      req_chan.valid <= 1'b0;
      while (pending_status.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d transactions (%0d keys) over several register settings, %0d steps seen.",
               items_sent, keys_sent, steps_seen);
      $display("Checked %0d responses, %0d receiver hold-offs, %0d mismatches.",
               checked, hold_offs, errors);
      if (errors == 0) begin
         $display("stepper_phase_sequencer_top_tb OK");
      end else begin
         $display("stepper_phase_sequencer_top_tb NOT OK");
      end
      $finish;
   end

endmodule
